// File: design/vfc_pkg.sv
// ============================================================================
// vfc_pkg
// Shared types, constants and helper functions of the voxel face cull mesher.
// ============================================================================
package vfc_pkg;

    localparam int CHUNK_SIDE_DEF = 16;

    localparam logic [15:0] HALF_SIZE_RST = 16'd128;

    localparam logic signed [31:0] POS_MAX = 32'sd2097151;
    localparam logic signed [31:0] POS_MIN = -32'sd2097152;

    // Input opcodes.
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_MESH  = 1'b1;

    // Face codes, also the bit positions of the visibility mask.
    localparam logic [2:0] FACE_LEFT   = 3'd0;
    localparam logic [2:0] FACE_RIGHT  = 3'd1;
    localparam logic [2:0] FACE_BOTTOM = 3'd2;
    localparam logic [2:0] FACE_TOP    = 3'd3;
    localparam logic [2:0] FACE_BACK   = 3'd4;
    localparam logic [2:0] FACE_FRONT  = 3'd5;

    // Store read steps: the voxel itself, then the neighbor across each face.
    localparam logic [2:0] STEP_CENTER = 3'd0;
    localparam logic [2:0] STEP_LEFT   = 3'd1;
    localparam logic [2:0] STEP_RIGHT  = 3'd2;
    localparam logic [2:0] STEP_BOTTOM = 3'd3;
    localparam logic [2:0] STEP_TOP    = 3'd4;
    localparam logic [2:0] STEP_BACK   = 3'd5;
    localparam logic [2:0] STEP_FRONT  = 3'd6;

    localparam logic [2:0] VTX_FIRST = 3'd0;
    localparam logic [2:0] VTX_LAST  = 3'd5;

    // Two triangles per face, corner number is x*4 + y*2 + z.
    localparam logic [2:0] FACE_CORNERS [6][6] = '{
        '{3'd0, 3'd2, 3'd1, 3'd1, 3'd2, 3'd3},
        '{3'd4, 3'd5, 3'd6, 3'd5, 3'd7, 3'd6},
        '{3'd0, 3'd1, 3'd5, 3'd0, 3'd5, 3'd4},
        '{3'd2, 3'd6, 3'd7, 3'd2, 3'd7, 3'd3},
        '{3'd0, 3'd4, 3'd6, 3'd0, 3'd6, 3'd2},
        '{3'd1, 3'd3, 3'd7, 3'd1, 3'd7, 3'd5}
    };

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_DRAIN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic       wr_en;
        logic       mesh_ld;
        logic       rd_en;
        logic [2:0] rd_step;
        logic       out_ld;
        logic       out_last;
        logic [2:0] face;
        logic [2:0] vtx;
    } ctrl_cmd_t;

    typedef struct packed {
        logic       in_range;
        logic       solid;
        logic [5:0] vis;
        logic       out_free;
    } dp_stat_t;

    function automatic logic [2:0] face_corner(logic [2:0] face, logic [2:0] vtx);
        logic [2:0] c;
        c = 3'd0;
        if (face <= FACE_FRONT && vtx <= VTX_LAST)
        begin
            c = FACE_CORNERS[face][vtx];
        end
        return c;
    endfunction

    // True when some face after the given one is visible.
    function automatic logic vis_above(logic [5:0] vis, logic [2:0] face);
        logic r;
        r = 1'b0;
        for (int i = 0; i < 6; i++)
        begin
            if (3'(i) > face && vis[i])
            begin
                r = 1'b1;
            end
        end
        return r;
    endfunction

endpackage

// File: design/vfc_ifs.sv
// ============================================================================
// vfc channel interfaces
// Valid/ready channels for mesh items, vertices and the size register write.
// ============================================================================
interface vfc_in_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [3:0]  vox_x;
    logic [3:0]  vox_y;
    logic [3:0]  vox_z;
    logic        air_in;
    logic [23:0] colour_in;

    modport source (output valid, output opcode, output vox_x, output vox_y,
                    output vox_z, output air_in, output colour_in, input ready);
    modport sink (input valid, input opcode, input vox_x, input vox_y,
                  input vox_z, input air_in, input colour_in, output ready);
endinterface

interface vfc_out_if;
    logic               valid;
    logic               ready;
    logic signed [21:0] pos_x;
    logic signed [21:0] pos_y;
    logic signed [21:0] pos_z;
    logic [23:0]        colour_out;
    logic [2:0]         face_id;
    logic [2:0]         corner_id;
    logic               last_vertex;

    modport source (output valid, output pos_x, output pos_y, output pos_z,
                    output colour_out, output face_id, output corner_id,
                    output last_vertex, input ready);
    modport sink (input valid, input pos_x, input pos_y, input pos_z,
                  input colour_out, input face_id, input corner_id,
                  input last_vertex, output ready);
endinterface

interface vfc_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] half_voxel_size;

    modport source (output valid, output half_voxel_size, input ready);
    modport sink (input valid, input half_voxel_size, output ready);
endinterface

// File: design/voxel_face_cull_mesher.sv
// ============================================================================
// voxel_face_cull_mesher
// Stores a chunk of voxels and emits the vertices of the visible faces of one.
// ============================================================================
//
//  channel    dir   carries
//  ---------  ----  ----------------------------------------------------------
//  in_chan    in    opcode, vox_x/y/z, air_in, colour_in (write or mesh item)
//  out_chan   out   pos_x/y/z, colour_out, face_id, corner_id, last_vertex
//  cfg_chan   in    half_voxel_size (Q8.8)
//
// A write transaction is stored from the idle state. A mesh transaction is
// accepted in the idle state, then reads the voxel and its six neighbors on
// the single store port, lands the last read and, if the voxel is solid, emits
// each vertex and steps over each hidden face before the last visible one.
// New items are taken only when the sequencer is idle; the output register
// lets a finished vertex wait while the next item starts.
// A stalled out_chan holds the sequencer on a vertex it emits. After reset the
// size register is 0.5 and the store contents are undefined until written.
//
module voxel_face_cull_mesher #(
    parameter int CHUNK_SIDE = vfc_pkg::CHUNK_SIDE_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    vfc_in_if.sink     in_chan,
    vfc_out_if.source  out_chan,
    vfc_cfg_if.sink    cfg_chan
);
    import vfc_pkg::*;

    ctrl_cmd_t cmd;
    dp_stat_t  stat;
    logic      in_ready;

    assign in_chan.ready = in_ready;

    vfc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_chan.valid),
        .in_opcode (in_chan.opcode),
        .in_ready  (in_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    vfc_datapath #(
        .CHUNK_SIDE (CHUNK_SIDE)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .vox_x     (in_chan.vox_x),
        .vox_y     (in_chan.vox_y),
        .vox_z     (in_chan.vox_z),
        .air_in    (in_chan.air_in),
        .colour_in (in_chan.colour_in),
        .cmd       (cmd),
        .stat      (stat),
        .cfg_chan  (cfg_chan),
        .out_chan  (out_chan)
    );

endmodule

// File: design/vfc_ctrl.sv
// ============================================================================
// vfc_ctrl
// Sequencer: accepts items, walks the seven store reads, then the vertices.
// ============================================================================
module vfc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_opcode,
    output logic                in_ready,
    input  vfc_pkg::dp_stat_t   stat,
    output vfc_pkg::ctrl_cmd_t  cmd
);
    import vfc_pkg::*;

    state_t     state_reg, state_next;
    logic [2:0] step_reg, step_next;
    logic [2:0] face_reg, face_next;
    logic [2:0] vtx_reg, vtx_next;
    logic       face_vis;
    logic       more_faces;

    assign face_vis   = stat.vis[face_reg];
    assign more_faces = vis_above(stat.vis, face_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= STEP_CENTER;
            face_reg  <= FACE_LEFT;
            vtx_reg   <= VTX_FIRST;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            face_reg  <= face_next;
            vtx_reg   <= vtx_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        face_next  = face_reg;
        vtx_next   = vtx_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && in_opcode == OP_MESH && stat.in_range)
                begin
                    state_next = ST_READ;
                    step_next  = STEP_CENTER;
                end
            end
            ST_READ:
            begin
                if (step_reg == STEP_FRONT)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    step_next = step_reg + 3'd1;
                end
            end
            ST_DRAIN:
            begin
                if (stat.solid)
                begin
                    state_next = ST_EMIT;
                    face_next  = FACE_LEFT;
                    vtx_next   = VTX_FIRST;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                if (!face_vis)
                begin
                    if (face_reg == FACE_FRONT || !more_faces)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        face_next = face_reg + 3'd1;
                        vtx_next  = VTX_FIRST;
                    end
                end
                else if (stat.out_free)
                begin
                    if (vtx_reg == VTX_LAST)
                    begin
                        if (!more_faces)
                        begin
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            face_next = face_reg + 3'd1;
                            vtx_next  = VTX_FIRST;
                        end
                    end
                    else
                    begin
                        vtx_next = vtx_reg + 3'd1;
                    end
                end
            end
        endcase
    end

    always_comb
    begin
        in_ready     = 1'b0;
        cmd          = '0;
        cmd.rd_step  = step_reg;
        cmd.face     = face_reg;
        cmd.vtx      = vtx_reg;
        cmd.out_last = (vtx_reg == VTX_LAST) && !more_faces;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.wr_en   = in_valid && in_opcode == OP_WRITE && stat.in_range;
                cmd.mesh_ld = in_valid && in_opcode == OP_MESH;
            end
            ST_READ:
            begin
                cmd.rd_en = 1'b1;
            end
            ST_DRAIN:
            begin
                cmd.rd_en = 1'b0;
            end
            ST_EMIT:
            begin
                cmd.out_ld = face_vis && stat.out_free;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_ld |-> stat.out_free)
        else $error("vertex loaded while the output register is still full");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_ld && cmd.out_last |=> state_reg == ST_IDLE)
        else $error("sequencer kept running after the final vertex");

    a_port_shared: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_en |-> !cmd.wr_en && !in_ready)
        else $error("store write or new item during a read sweep");
`endif

endmodule

// File: design/vfc_datapath.sv
// ============================================================================
// vfc_datapath
// Voxel store, neighbor visibility, vertex position math and output register.
// ============================================================================
module vfc_datapath #(
    parameter int CHUNK_SIDE = vfc_pkg::CHUNK_SIDE_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [3:0]         vox_x,
    input  logic [3:0]         vox_y,
    input  logic [3:0]         vox_z,
    input  logic               air_in,
    input  logic [23:0]        colour_in,
    input  vfc_pkg::ctrl_cmd_t cmd,
    output vfc_pkg::dp_stat_t  stat,
    vfc_cfg_if.sink            cfg_chan,
    vfc_out_if.source          out_chan
);
    import vfc_pkg::*;

    localparam int CW    = $clog2(CHUNK_SIDE);
    localparam int AW    = 3 * CW;
    localparam int DEPTH = 2 ** AW;
    localparam int MW    = CW + 2;
    localparam int PW    = CW + 19;
    localparam logic [CW-1:0] C_LAST = CW'(CHUNK_SIDE - 1);

    logic [15:0]        half_size_reg;
    logic [CW-1:0]      x_reg, y_reg, z_reg;
    logic [24:0]        mem [DEPTH];
    logic [24:0]        rdata_reg;
    logic [AW-1:0]      wr_addr, rd_addr, mem_addr;
    logic               rd_valid_reg;
    logic [2:0]         rd_step_reg;
    logic               solid_reg;
    logic [23:0]        colour_reg;
    logic [5:0]         vis_reg, vis_next;
    logic [5:0]         on_edge;
    logic               out_valid_reg, out_valid_next;
    logic signed [21:0] pos_x_reg, pos_y_reg, pos_z_reg;
    logic [23:0]        colour_out_reg;
    logic [2:0]         face_id_reg, corner_id_reg;
    logic               last_reg;
    logic [2:0]         corner;
    logic               in_range;

    // Position of a cube side: (2c+1)*h on the high side, (2c-1)*h on the low side.
    function automatic logic signed [21:0] pos_calc(logic [CW-1:0] c, logic hi,
                                                    logic [15:0] h);
        logic signed [MW-1:0] m;
        logic signed [PW-1:0] p;
        logic signed [31:0]   w;
        logic signed [31:0]   s;
        m = hi ? $signed({1'b0, c, 1'b1}) : ($signed({1'b0, c, 1'b0}) - $signed(MW'(1)));
        p = m * $signed({1'b0, h});
        w = 32'(p);
        if (w > POS_MAX)
        begin
            s = POS_MAX;
        end
        else if (w < POS_MIN)
        begin
            s = POS_MIN;
        end
        else
        begin
            s = w;
        end
        return s[21:0];
    endfunction

    assign in_range = ({28'd0, vox_x} < 32'(CHUNK_SIDE)) &&
                      ({28'd0, vox_y} < 32'(CHUNK_SIDE)) &&
                      ({28'd0, vox_z} < 32'(CHUNK_SIDE));

    // Configuration register.
    assign cfg_chan.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_size_reg <= HALF_SIZE_RST;
        end
        else if (cfg_chan.valid)
        begin
            half_size_reg <= cfg_chan.half_voxel_size;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mesh_ld)
        begin
            x_reg <= CW'(vox_x);
            y_reg <= CW'(vox_y);
            z_reg <= CW'(vox_z);
        end
    end

    // Store addressing: the voxel itself or the neighbor across one face.
    // Neighbor addresses on the chunk edge wrap; their data is not used.
    assign wr_addr = {CW'(vox_x), CW'(vox_y), CW'(vox_z)};

    always_comb
    begin
        unique case (cmd.rd_step)
            STEP_LEFT:   rd_addr = {x_reg - CW'(1), y_reg, z_reg};
            STEP_RIGHT:  rd_addr = {x_reg + CW'(1), y_reg, z_reg};
            STEP_BOTTOM: rd_addr = {x_reg, y_reg - CW'(1), z_reg};
            STEP_TOP:    rd_addr = {x_reg, y_reg + CW'(1), z_reg};
            STEP_BACK:   rd_addr = {x_reg, y_reg, z_reg - CW'(1)};
            STEP_FRONT:  rd_addr = {x_reg, y_reg, z_reg + CW'(1)};
            default:     rd_addr = {x_reg, y_reg, z_reg};
        endcase
    end

    assign mem_addr = cmd.wr_en ? wr_addr : rd_addr;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[mem_addr] <= {air_in, colour_in};
        end
        rdata_reg <= mem[mem_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg <= 1'b0;
            rd_step_reg  <= STEP_CENTER;
        end
        else
        begin
            rd_valid_reg <= cmd.rd_en;
            rd_step_reg  <= cmd.rd_step;
        end
    end

    assign on_edge = {z_reg == C_LAST, z_reg == '0, y_reg == C_LAST, y_reg == '0,
                      x_reg == C_LAST, x_reg == '0};

    always_comb
    begin
        vis_next = vis_reg;
        if (rd_valid_reg && rd_step_reg != STEP_CENTER)
        begin
            vis_next[rd_step_reg - 3'd1] = on_edge[rd_step_reg - 3'd1] | rdata_reg[24];
        end
    end

    always_ff @(posedge clk)
    begin
        vis_reg <= vis_next;
        if (rd_valid_reg && rd_step_reg == STEP_CENTER)
        begin
            solid_reg  <= ~rdata_reg[24];
            colour_reg <= rdata_reg[23:0];
        end
    end

    // Output register.
    assign corner         = face_corner(cmd.face, cmd.vtx);
    assign out_valid_next = cmd.out_ld | (out_valid_reg & ~out_chan.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_ld)
        begin
            pos_x_reg      <= pos_calc(x_reg, corner[2], half_size_reg);
            pos_y_reg      <= pos_calc(y_reg, corner[1], half_size_reg);
            pos_z_reg      <= pos_calc(z_reg, corner[0], half_size_reg);
            colour_out_reg <= colour_reg;
            face_id_reg    <= cmd.face;
            corner_id_reg  <= corner;
            last_reg       <= cmd.out_last;
        end
    end

    assign out_chan.valid       = out_valid_reg;
    assign out_chan.pos_x       = pos_x_reg;
    assign out_chan.pos_y       = pos_y_reg;
    assign out_chan.pos_z       = pos_z_reg;
    assign out_chan.colour_out  = colour_out_reg;
    assign out_chan.face_id     = face_id_reg;
    assign out_chan.corner_id   = corner_id_reg;
    assign out_chan.last_vertex = last_reg;

    assign stat.in_range = in_range;
    assign stat.solid    = solid_reg;
    assign stat.vis      = vis_reg;
    assign stat.out_free = ~out_valid_reg | out_chan.ready;

endmodule
